// ===== rtl/ppd_pkg.sv =====
package ppd_pkg;

   // field and datapath widths
   localparam int VW       = 21;   // speed limit and track width
   localparam int DXW      = 33;   // goal offset, signed
   localparam int SW       = 32;   // sine/cosine, signed Q30
   localparam int EW       = 36;   // lateral offset, signed
   localparam int MAGW     = 36;   // magnitude of lateral offset
   localparam int D2W      = 66;   // squared distance
   localparam int MTW      = MAGW + VW;
   localparam int DENW     = 67;   // divisor
   localparam int LNW      = 87;   // linear speed numerator
   localparam int QW       = 32;   // quotient bits kept
   localparam int DIV_LAT  = QW + 1;
   localparam int SIN_LAT  = 7;

   // odd degree-9 quarter-wave sine, Q30
   localparam logic signed [31:0] SC1 = 32'sd1686629713;
   localparam logic signed [31:0] SC3 = -32'sd693598668;
   localparam logic signed [31:0] SC5 = 32'sd85569306;
   localparam logic signed [31:0] SC7 = -32'sd5026995;
   localparam logic signed [31:0] SC9 = 32'sd172274;
   localparam logic [30:0]        Q30_ONE = 31'h4000_0000;

   localparam logic [VW-1:0] TRACK_RESET = 21'd26214;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_DIST = 2'd1,
      ST_SAT       = 2'd2,
      ST_PATH_END  = 2'd3
   } status_type;

   typedef struct packed {
      logic                  pe;
      logic                  zero;
      logic signed [DXW-1:0] dx;
      logic signed [DXW-1:0] dy;
      logic [1:0]            quad;
      logic [VW-1:0]         v;
   } geo_type;

   typedef struct packed {
      logic pe;
      logic zero;
      logic eneg;
   } ctl_type;

endpackage

// ===== rtl/ppd_sin.sv =====
// Quarter-wave sine, Horner evaluation, one multiply per stage
module ppd_sin import ppd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [30:0]          in_arg,
   output logic                 out_valid,
   output logic signed [SW-1:0] out_val
);

   logic                vld_ff [0:SIN_LAT-1];
   logic [61:0]         sq_ff;
   logic signed [31:0]  u_ff [0:4];
   logic signed [31:0]  w_ff [0:2];
   logic signed [63:0]  prod_ff [0:4];
   logic signed [SW-1:0] res_ff;
   logic [61:0]         w_wide;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIN_LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < SIN_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign w_wide = sq_ff >> 30;

   // square of the argument, then first Horner product
   always_ff @(posedge clock) begin
      sq_ff      <= {31'b0, in_arg} * {31'b0, in_arg};
      u_ff[0]    <= {1'b0, in_arg};
      w_ff[0]    <= w_wide[31:0];
      u_ff[1]    <= u_ff[0];
      prod_ff[0] <= SC9 * $signed(w_wide[31:0]);
   end

   // remaining Horner steps
   for (genvar j = 0; j < 4; j++) begin : g_horner
      logic signed [63:0] sh;
      logic signed [31:0] cf;
      logic signed [31:0] p;
      assign sh = prod_ff[j] >>> 30;
      assign cf = (j == 0) ? SC7 : (j == 1) ? SC5 : (j == 2) ? SC3 : SC1;
      assign p  = cf + sh[31:0];
      if (j < 3) begin : g_w
         always_ff @(posedge clock) begin
            prod_ff[j+1] <= p * w_ff[j];
            u_ff[j+2]    <= u_ff[j+1];
         end
         if (j < 2) begin : g_wd
            always_ff @(posedge clock) begin
               w_ff[j+1] <= w_ff[j];
            end
         end
      end else begin : g_u
         always_ff @(posedge clock) begin
            prod_ff[j+1] <= p * u_ff[j+1];
         end
      end
   end

   // final scale
   logic signed [63:0] fin_sh;
   assign fin_sh = prod_ff[4] >>> 30;

   always_ff @(posedge clock) begin
      res_ff <= fin_sh[SW-1:0];
   end

   assign out_valid = vld_ff[SIN_LAT-1];
   assign out_val   = res_ff;

endmodule

// ===== rtl/ppd_div.sv =====
// Restoring divider, one quotient bit per stage; quotient at or above
// 2^QW is flagged instead of computed
module ppd_div import ppd_pkg::*; #(
   parameter int NW = 81,
   parameter int DW = 67
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic          out_big
);

   localparam int HW = NW - QW;
   localparam int CW = (HW > DW) ? HW : DW;

   logic          vld_ff [0:QW];
   logic          big_ff [0:QW];
   logic [DW-1:0] rem_ff [0:QW-1];
   logic [QW-1:0] lo_ff  [0:QW-1];
   logic [DW-1:0] dv_ff  [0:QW-1];
   logic [QW-1:0] q_ff   [1:QW];

   logic [CW-1:0] nh;
   logic [CW-1:0] dx;

   assign nh = CW'(num[NW-1:QW]);
   assign dx = CW'(den);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= QW; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // overflow check and initial remainder
   always_ff @(posedge clock) begin
      big_ff[0] <= (nh >= dx);
      rem_ff[0] <= nh[DW-1:0];
      lo_ff[0]  <= num[QW-1:0];
      dv_ff[0]  <= den;
   end

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW:0]   t;
      logic [DW:0]   diff;
      logic          ge;
      logic [QW-1:0] qp;
      assign t    = {rem_ff[i], lo_ff[i][QW-1]};
      assign diff = t - {1'b0, dv_ff[i]};
      assign ge   = (t >= {1'b0, dv_ff[i]});
      if (i == 0) begin : g_q0
         assign qp = '0;
      end else begin : g_qn
         assign qp = q_ff[i];
      end
      always_ff @(posedge clock) begin
         q_ff[i+1]   <= {qp[QW-2:0], ge};
         big_ff[i+1] <= big_ff[i];
      end
      if (i < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[i+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
            lo_ff[i+1]  <= {lo_ff[i][QW-2:0], 1'b0};
            dv_ff[i+1]  <= dv_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign quo       = q_ff[QW];
   assign out_big   = big_ff[QW];

endmodule

// ===== rtl/pure_pursuit_diff_drive.sv =====
// Throughput: one word per cycle; the two 33-stage dividers and the
// seven-stage sine pipelines each take a new operand every cycle.
// busy is high only during reset; results cannot be held off.
// Reset (synchronous) clears all valid bits and sets track width to 0.4 m.
module pure_pursuit_diff_drive import ppd_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_goal_north,
   input  logic signed [31:0] req_goal_east,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   input  logic [20:0]        req_speed_limit,
   input  logic               req_path_end,
   input  logic               csr_we,
   input  logic [20:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_linear_speed,
   output logic signed [31:0] rsp_turn_rate,
   output logic [1:0]         rsp_status
);

   localparam int WNW = MTW + FRAC_BITS + 1;

   logic [VW-1:0] track_ff;

   // track width register
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= TRACK_RESET;
      end else if (csr_we) begin
         track_ff <= csr_wdata;
      end
   end

   assign busy = reset;

   // ---------------- entry stage ----------------
   logic                  acc;
   logic signed [DXW-1:0] dx_in, dy_in;
   logic [23:0]           hx;
   logic [ANGLE_BITS-1:0] ang;
   geo_type               geo_in;
   logic                  s1_vld_ff;
   geo_type               s1_geo_ff;
   logic [29:0]           s1_u_ff;

   assign acc   = start && !busy;
   assign dx_in = $signed({req_goal_north[31], req_goal_north})
                - $signed({req_pos_x[31], req_pos_x});
   assign dy_in = $signed({req_goal_east[31], req_goal_east})
                - $signed({req_pos_y[31], req_pos_y});
   assign hx    = {{8{req_heading[15]}}, req_heading};
   assign ang   = hx[ANGLE_BITS-1:0];

   always_comb begin
      geo_in.pe   = req_path_end;
      geo_in.zero = (dx_in == '0) && (dy_in == '0);
      geo_in.dx   = dx_in;
      geo_in.dy   = dy_in;
      geo_in.quad = ang[ANGLE_BITS-1 -: 2];
      geo_in.v    = req_speed_limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= acc;
      end
      s1_geo_ff <= geo_in;
      s1_u_ff   <= {ang[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
   end

   // ---------------- sine and cosine ----------------
   logic                 sn_vld, cs_vld;
   logic signed [SW-1:0] sn_val, cs_val;
   geo_type              geo_dl_ff [0:SIN_LAT-1];

   ppd_sin u_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_arg    ({1'b0, s1_u_ff}),
      .out_valid (sn_vld),
      .out_val   (sn_val)
   );

   ppd_sin u_cos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_arg    (Q30_ONE - {1'b0, s1_u_ff}),
      .out_valid (cs_vld),
      .out_val   (cs_val)
   );

   // side data waits alongside the sine pipeline
   always_ff @(posedge clock) begin
      geo_dl_ff[0] <= s1_geo_ff;
      for (int k = 1; k < SIN_LAT; k++) geo_dl_ff[k] <= geo_dl_ff[k-1];
   end

   // ---------------- rotation products ----------------
   geo_type               gm;
   logic signed [SW-1:0]  s_sel, c_sel;
   logic [DXW-1:0]        ax, ay;
   logic                  m_vld_ff;
   logic signed [64:0]    pdc_ff, pdx_ff;
   logic [D2W-1:0]        sqx_ff, sqy_ff;
   logic                  m_pe_ff, m_zero_ff;
   logic [VW-1:0]         m_v_ff;

   assign gm = geo_dl_ff[SIN_LAT-1];

   // quadrant folding
   always_comb begin
      case (gm.quad)
         2'd0: begin
            s_sel = sn_val;  c_sel = cs_val;
         end
         2'd1: begin
            s_sel = cs_val;  c_sel = -sn_val;
         end
         2'd2: begin
            s_sel = -sn_val; c_sel = -cs_val;
         end
         default: begin
            s_sel = -cs_val; c_sel = sn_val;
         end
      endcase
   end

   assign ax = gm.dx[DXW-1] ? DXW'(-gm.dx) : DXW'(gm.dx);
   assign ay = gm.dy[DXW-1] ? DXW'(-gm.dy) : DXW'(gm.dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= sn_vld && cs_vld;
      end
      pdc_ff    <= gm.dy * c_sel;
      pdx_ff    <= gm.dx * s_sel;
      sqx_ff    <= D2W'(ax) * D2W'(ax);
      sqy_ff    <= D2W'(ay) * D2W'(ay);
      m_pe_ff   <= gm.pe;
      m_zero_ff <= gm.zero;
      m_v_ff    <= gm.v;
   end

   // ---------------- lateral offset, squared distance ----------------
   logic signed [65:0]   ediff;
   logic signed [65:0]   esh;
   logic                 e_vld_ff;
   logic signed [EW-1:0] e_ff;
   logic [D2W-1:0]       d2_ff;
   logic                 e_pe_ff, e_zero_ff;
   logic [VW-1:0]        e_v_ff;

   assign ediff = pdc_ff - pdx_ff;
   assign esh   = ediff >>> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= m_vld_ff;
      end
      e_ff      <= esh[EW-1:0];
      d2_ff     <= sqx_ff + sqy_ff;
      e_pe_ff   <= m_pe_ff;
      e_zero_ff <= m_zero_ff;
      e_v_ff    <= m_v_ff;
   end

   // ---------------- partial products ----------------
   logic [MAGW-1:0] mag;
   logic            p_vld_ff;
   logic [MTW-1:0]  mt_ff, mv_ff;
   logic [53:0]     llo_ff, lhi_ff;
   logic [D2W-1:0]  p_d2_ff;
   ctl_type         p_ctl_ff;

   assign mag = e_ff[EW-1] ? MAGW'(-e_ff) : MAGW'(e_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= e_vld_ff;
      end
      mt_ff         <= MTW'(mag) * MTW'(track_ff);
      mv_ff         <= MTW'(mag) * MTW'(e_v_ff);
      llo_ff        <= 54'(d2_ff[32:0]) * 54'(e_v_ff);
      lhi_ff        <= 54'(d2_ff[65:33]) * 54'(e_v_ff);
      p_d2_ff       <= d2_ff;
      p_ctl_ff.pe   <= e_pe_ff;
      p_ctl_ff.zero <= e_zero_ff;
      p_ctl_ff.eneg <= e_ff[EW-1];
   end

   // ---------------- divider operands ----------------
   logic            d_vld_ff;
   logic [DENW-1:0] den_ff;
   logic [WNW-1:0]  wn_ff;
   logic [LNW-1:0]  ln_ff;
   ctl_type         d_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= p_vld_ff;
      end
      den_ff   <= DENW'(p_d2_ff) + DENW'(mt_ff);
      wn_ff    <= WNW'(mv_ff) << (FRAC_BITS + 1);
      ln_ff    <= LNW'(llo_ff) + (LNW'(lhi_ff) << 33);
      d_ctl_ff <= p_ctl_ff;
   end

   // ---------------- dividers ----------------
   logic          tq_vld, lq_vld, tq_big, lq_big;
   logic [QW-1:0] tq, lq;
   ctl_type       ctl_dl_ff [0:DIV_LAT-1];

   ppd_div #(.NW(WNW), .DW(DENW)) u_div_turn (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .num       (wn_ff),
      .den       (den_ff),
      .out_valid (tq_vld),
      .quo       (tq),
      .out_big   (tq_big)
   );

   ppd_div #(.NW(LNW), .DW(DENW)) u_div_lin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .num       (ln_ff),
      .den       (den_ff),
      .out_valid (lq_vld),
      .quo       (lq),
      .out_big   (lq_big)
   );

   always_ff @(posedge clock) begin
      ctl_dl_ff[0] <= d_ctl_ff;
      for (int k = 1; k < DIV_LAT; k++) ctl_dl_ff[k] <= ctl_dl_ff[k-1];
   end

   // ---------------- saturation and status ----------------
   ctl_type            cf;
   logic signed [31:0] turn_in, lin_in;
   logic               tsat, lsat;
   status_type         status_in;
   logic               out_vld_ff;
   logic signed [31:0] out_lin_ff, out_turn_ff;
   status_type         out_status_ff;

   assign cf = ctl_dl_ff[DIV_LAT-1];

   always_comb begin
      if (cf.eneg) begin
         tsat    = tq_big || (tq > 32'h8000_0000);
         turn_in = tsat ? 32'sh8000_0000 : -$signed(tq);
      end else begin
         tsat    = tq_big || tq[31];
         turn_in = tsat ? 32'sh7FFF_FFFF : $signed(tq);
      end
      lsat   = lq_big || lq[31];
      lin_in = lsat ? 32'sh7FFF_FFFF : $signed(lq);
      if (cf.pe) begin
         status_in = ST_PATH_END;
         turn_in   = '0;
         lin_in    = '0;
      end else if (cf.zero) begin
         status_in = ST_ZERO_DIST;
         turn_in   = '0;
         lin_in    = '0;
      end else if (tsat || lsat) begin
         status_in = ST_SAT;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= tq_vld && lq_vld;
      end
      out_lin_ff    <= lin_in;
      out_turn_ff   <= turn_in;
      out_status_ff <= status_in;
   end

   assign rsp_strobe       = out_vld_ff;
   assign rsp_linear_speed = out_lin_ff;
   assign rsp_turn_rate    = out_turn_ff;
   assign rsp_status       = out_status_ff;

   // ---------------- checks ----------------
   a_div_align: assert property (@(posedge clock) disable iff (reset)
      tq_vld == lq_vld)
      else $error("divider valid bits out of step");

   a_lin_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rsp_linear_speed[31])
      else $error("negative linear speed");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_PATH_END || rsp_status == ST_ZERO_DIST)
      |-> rsp_linear_speed == '0 && rsp_turn_rate == '0)
      else $error("stop word carries nonzero speeds");

   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_SAT
      |-> rsp_linear_speed == 32'sh7FFF_FFFF || rsp_turn_rate == 32'sh7FFF_FFFF
          || rsp_turn_rate == 32'sh8000_0000)
      else $error("saturated status without a clamped output");

endmodule
